[design/spi_clock_divider_search_unit_assert.svh]
// Assertion macros used by the checker of the divider search unit.
`ifndef SPI_CLOCK_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_UNIT_ASSERT_SVH

// General property, checked at each rising edge outside reset.
`define SCDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A stalled signal must hold its value into the next cycle.
`define SCDS_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

[design/scds_pkg.sv]
package scds_pkg;

  // Width of the frequency operands and of the divider.
  localparam int DIV_W = 32;

  // Output field widths.
  localparam int PRESCALE_W = 8;
  localparam int RATE_W     = 8;

  // Default largest half prescale.
  localparam int MAX_HALF_PRESCALE_DEF = 127;

  // Largest second stage divider value.
  localparam int STAGE_MAX = 256;
  localparam int STAGE_W   = 9;

  // Peripheral clock after reset, in hertz.
  localparam logic [DIV_W-1:0] PCLK_RESET = 32'd100000000;

  // Operand selection of the shared divider.
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t SEL_Q1 = 2'd0;  // pclk / b
  localparam div_sel_t SEL_Q2 = 2'd1;  // q1 / f
  localparam div_sel_t SEL_Q3 = 2'd2;  // q1 / s

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     init;        // capture the target and restart the search
    logic     div_start;   // launch the divider on the selected operands
    div_sel_t div_sel;     // operand selection and capture destination
    logic     capture;     // store the divider quotient
    logic     take_first;  // remember the clamped stage of the first candidate
    logic     eval;        // keep the candidate if its error is smaller
    logic     dec_b;       // step to the next smaller half prescale
    logic     out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;  // quotient is ready
    logic f_zero;    // target frequency is zero
    logic s_ok;      // second stage lies in 1..256
    logic better;    // candidate error beats the best so far
    logic exact;     // candidate error is zero
    logic b_first;   // current half prescale is the largest one
    logic b_last;    // current half prescale is one
  } sts_t;

endpackage

[design/scds_in_if.sv]
interface scds_in_if;
  import scds_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIV_W-1:0] target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink (input valid, input target_hz, output ready);
endinterface

[design/scds_out_if.sv]
interface scds_out_if;
  import scds_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PRESCALE_W-1:0] prescale;
  logic [RATE_W-1:0]     rate_minus_one;
  logic                  bad_target;

  modport source (output valid, output prescale, output rate_minus_one, output bad_target,
                  input ready);
  modport sink (input valid, input prescale, input rate_minus_one, input bad_target,
                output ready);
endinterface

[design/scds_div.sv]
module scds_div
  import scds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem, quo[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = (rem_sh >= {1'b0, dsr});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient bits, one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[design/scds_datapath.sv]
module scds_datapath
  import scds_pkg::*;
#(
  parameter int MAX_HALF_PRESCALE = MAX_HALF_PRESCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DIV_W-1:0]      cfg_wdata,
  input  logic [DIV_W-1:0]      target_hz,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [PRESCALE_W-1:0] prescale,
  output logic [RATE_W-1:0]     rate_minus_one,
  output logic                  bad_target
);

  localparam int B_W = $clog2(MAX_HALF_PRESCALE + 1);
  localparam logic [B_W-1:0] B_MAX = B_W'(MAX_HALF_PRESCALE);
  localparam logic [B_W-1:0] B_ONE = B_W'(1);

  logic [DIV_W-1:0]   pclk;
  logic [DIV_W-1:0]   f;
  logic [B_W-1:0]     b;
  logic [B_W-1:0]     best_b;
  logic [DIV_W-1:0]   best_err;
  logic [STAGE_W-1:0] best_s;
  logic [DIV_W-1:0]   q1;
  logic [DIV_W-1:0]   q2;
  logic [DIV_W-1:0]   q3;

  logic [DIV_W-1:0]   dividend;
  logic [DIV_W-1:0]   divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;

  logic [DIV_W-1:0]   s;
  logic [STAGE_W-1:0] s_clamped;
  logic [DIV_W-1:0]   got;
  logic [DIV_W-1:0]   err;

  // Peripheral clock register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pclk <= PCLK_RESET;
    end else if (cfg_we) begin
      pclk <= cfg_wdata;
    end
  end

  // Operand selection of the shared divider.
  always_comb begin
    case (cmd.div_sel)
      SEL_Q1: begin
        dividend = pclk;
        divisor  = DIV_W'(b);
      end
      SEL_Q2: begin
        dividend = q1;
        divisor  = f;
      end
      default: begin
        dividend = q1;
        divisor  = s;
      end
    endcase
  end

  scds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Second stage: the quotient rounded up to even, then halved, plus a copy clamped to 1..256.
  always_comb begin
    s = {1'b0, q2[DIV_W-1:1]} + DIV_W'(q2[0]);
    if (s == '0) begin
      s_clamped = STAGE_W'(1);
    end else if (s > DIV_W'(STAGE_MAX)) begin
      s_clamped = STAGE_W'(STAGE_MAX);
    end else begin
      s_clamped = s[STAGE_W-1:0];
    end
  end

  // Achieved frequency and its distance from the target.
  always_comb begin
    got = {1'b0, q3[DIV_W-1:1]};
    err = (got >= f) ? (got - f) : (f - got);
  end

  // Status toward the controller.
  always_comb begin
    sts.div_done = div_done;
    sts.f_zero   = (f == '0);
    sts.s_ok     = (s != '0) && (s <= DIV_W'(STAGE_MAX));
    sts.better   = (err < best_err);
    sts.exact    = (err == '0);
    sts.b_first  = (b == B_MAX);
    sts.b_last   = (b == B_ONE);
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      f        <= target_hz;
      b        <= B_MAX;
      best_b   <= B_MAX;
      best_err <= pclk;
    end
    if (cmd.dec_b) begin
      b <= b - 1'b1;
    end
    if (cmd.capture) begin
      case (cmd.div_sel)
        SEL_Q1:  q1 <= quotient;
        SEL_Q2:  q2 <= quotient;
        default: q3 <= quotient;
      endcase
    end
    if (cmd.take_first) begin
      best_s <= s_clamped;
    end
    if (cmd.eval && sts.better) begin
      best_b   <= b;
      best_err <= err;
      best_s   <= s[STAGE_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.f_zero) begin
        prescale       <= '0;
        rate_minus_one <= '0;
        bad_target     <= 1'b1;
      end else begin
        prescale       <= PRESCALE_W'({best_b, 1'b0});
        rate_minus_one <= RATE_W'(best_s - 1'b1);
        bad_target     <= 1'b0;
      end
    end
  end

endmodule

[design/scds_ctrl.sv]
module scds_ctrl
  import scds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_WAIT1  = 4'd2;
  localparam logic [3:0] S_GO2    = 4'd3;
  localparam logic [3:0] S_WAIT2  = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_WAIT3  = 4'd6;
  localparam logic [3:0] S_EVAL   = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequencing of the candidate search.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_Q1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.init   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.f_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT1;
        end
      end
      S_WAIT1: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_next  = S_GO2;
        end
      end
      S_GO2: begin
        cmd.div_sel   = SEL_Q2;
        cmd.div_start = 1'b1;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.div_sel = SEL_Q2;
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.div_sel    = SEL_Q3;
        cmd.take_first = sts.b_first;
        if (sts.s_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT3;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_WAIT3: begin
        cmd.div_sel = SEL_Q3;
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.better && sts.exact) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.b_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.dec_b  = 1'b1;
          state_next = S_START;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/spi_clock_divider_search_unit.sv]
// A zero target is rejected without a search. Otherwise the half prescale steps down
// from MAX_HALF_PRESCALE to one, at most 127 candidates by default, each with three serial
// divisions (two when the second stage is out of range); an exact match ends the search.
// Throughput: one item per search; the next input transfer is taken once the result
// is in the output register. Reset: synchronous, clears the controller and output
// valid, sets the clock register to 100 MHz.
module spi_clock_divider_search_unit
  import scds_pkg::*;
#(
  parameter int MAX_HALF_PRESCALE = MAX_HALF_PRESCALE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DIV_W-1:0] cfg_wdata,
  scds_in_if.sink          in_ch,
  scds_out_if.source       out_ch
);

  cmd_t cmd;
  sts_t sts;

  scds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scds_datapath #(
    .MAX_HALF_PRESCALE (MAX_HALF_PRESCALE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .target_hz      (in_ch.target_hz),
    .cmd            (cmd),
    .sts            (sts),
    .prescale       (out_ch.prescale),
    .rate_minus_one (out_ch.rate_minus_one),
    .bad_target     (out_ch.bad_target)
  );

endmodule

[design/scds_checker.sv]
`include "spi_clock_divider_search_unit_assert.svh"

module scds_props
  import scds_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PRESCALE_W-1:0] prescale,
  input logic [RATE_W-1:0]     rate_minus_one,
  input logic                  bad_target
);

  // A waiting result stays offered.
  `SCDS_ASSERT_HOLD(a_out_valid_hold, clk, rst, out_valid, out_ready, out_valid, "result dropped")

  // A waiting result keeps its prescale.
  `SCDS_ASSERT_HOLD(a_out_data_hold, clk, rst, out_valid, out_ready, prescale, "prescale changed")

  // A rejected target gives zero divider values.
  `SCDS_ASSERT(a_bad_zero, clk, rst, (out_valid && bad_target) |-> (prescale == '0 && rate_minus_one == '0), "bad target with nonzero result")

  // A good result carries a nonzero even prescale.
  `SCDS_ASSERT(a_prescale_even, clk, rst, (out_valid && !bad_target) |-> (prescale != '0 && !prescale[0]), "prescale not even")

  // One search at a time: the input closes right after a transfer.
  `SCDS_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "second item taken during search")

endmodule

bind spi_clock_divider_search_unit scds_props u_scds_props (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .prescale       (out_ch.prescale),
  .rate_minus_one (out_ch.rate_minus_one),
  .bad_target     (out_ch.bad_target)
);
